// ----- rtl/core/lts_pkg.sv -----
// shared types and constants for the laser thickness supervisor
package lts_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED  = 2'd0,
        CFG_TOLERANCE = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_index_t;

    // field widths
    localparam int CODE_W  = 12;
    localparam int TIME_W  = 32;
    localparam int THICK_W = 15;
    localparam int EXP_W   = 16;
    localparam int TOL_W   = 12;
    localparam int TMO_W   = 16;

    // stream packing
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 3;

    // register reset values
    localparam logic [EXP_W-1:0] EXPECTED_RST  = 16'd0;
    localparam logic [TOL_W-1:0] TOLERANCE_RST = 12'd400;
    localparam logic [TMO_W-1:0] TIMEOUT_RST   = 16'd2000;

    // conversion constants
    localparam int MV_W = 14;
    localparam logic [MV_W-1:0] FULL_SCALE_MV = 14'd10000;
    localparam logic [7:0]      THICK_GAIN    = 8'd222;
    localparam int ADC_MAX     = 4095;
    localparam int THICK_SCALE = 100;
    localparam int THICK_MAX   = 22200;

    // shared constant divider: q = (x * recip) >> shift, then one correction step
    localparam int DIVIDEND_W  = 26;
    localparam int DIVISOR_W   = 13;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 31;
    localparam int PROD_W      = DIVIDEND_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_MV  = 32'((64'd1 << RECIP_SHIFT) / ADC_MAX);
    localparam logic [RECIP_W-1:0] RECIP_THK = 32'((64'd1 << RECIP_SHIFT) / THICK_SCALE);

    typedef enum logic [1:0] {
        DIV_MV  = 2'd0,
        DIV_THK = 2'd1,
        DIV_AVG = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul;
        logic     fix;
        logic     load_thk;
        logic     accum;
        logic     check;
        div_sel_t div_sel;
    } cmd_t;

    typedef struct packed {
        logic block_full;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/laser_thickness_supervisor.sv -----
// top level of the laser material thickness supervisor
//
// usage:
//   s_axis carries one laser sample per transfer: the adc code, a free-running
//   millisecond timestamp and the two print gates. every accepted sample gives
//   exactly one result on m_axis: the held average thickness, a flag that this
//   sample closed an averaging block, and the thin and thick alarms.
//   thin_alarm is the lift-up request, thick_alarm is a warning only.
//   the cfg port writes expected thickness, tolerance and timeout; write it
//   only while no sample is in flight.
// timing:
//   the sequencer handles one sample at a time through a shared
//   reciprocal-multiply divider (code to mv, mv to thickness, block average).
//   a result becomes valid in the same cycle that s_axis_tready rises again,
//   so a new sample is taken only after the last one has passed its check;
//   a sample that closes an averaging block also runs the average steps.
// reset:
//   rst_n clears the sum, count, held average, timers and the output valid,
//   and loads the register reset values (0 um, 400 um, 2000 ms).
// stall:
//   the result sits in an output register; the next sample is accepted and
//   worked on while it waits, and only the final check step holds until
//   m_axis_tready frees the register.
module laser_thickness_supervisor
    import lts_pkg::*;
#(
    parameter int AVG_SAMPLES = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // sample input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // adc_code[11:0], now_ms[43:12], zero pad
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // head_enable[0], at_print_height[1]
    // result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // avg_thickness_um[14:0], zero pad
    output logic [OUT_TUSER_W-1:0] m_axis_tuser   // avg_updated[0], thin_alarm[1], thick_alarm[2]
);

    cmd_t    cmd;
    status_t status;

    // sequencer: one sample in flight, steps through the divider phases
    lts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic, state and output register
    lts_datapath #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// ----- rtl/core/lts_ctrl.sv -----
// sequencer that steps one sample through conversion, averaging and window check
module lts_ctrl
    import lts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_tvalid,
    output logic    in_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_MUL_MV   = 10'b00_0000_0010,
        S_FIX_MV   = 10'b00_0000_0100,
        S_LOAD_THK = 10'b00_0000_1000,
        S_MUL_THK  = 10'b00_0001_0000,
        S_FIX_THK  = 10'b00_0010_0000,
        S_ACCUM    = 10'b00_0100_0000,
        S_MUL_AVG  = 10'b00_1000_0000,
        S_FIX_AVG  = 10'b01_0000_0000,
        S_CHECK    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.mul      = 1'b0;
        cmd.fix      = 1'b0;
        cmd.load_thk = 1'b0;
        cmd.accum    = 1'b0;
        cmd.check    = 1'b0;
        cmd.div_sel  = DIV_MV;
        case (state_reg)
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL_MV;
                end
            end
            S_MUL_MV:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIX_MV;
            end
            S_FIX_MV:
            begin
                cmd.fix    = 1'b1;
                state_next = S_LOAD_THK;
            end
            S_LOAD_THK:
            begin
                cmd.load_thk = 1'b1;
                state_next   = S_MUL_THK;
            end
            S_MUL_THK:
            begin
                cmd.mul     = 1'b1;
                cmd.div_sel = DIV_THK;
                state_next  = S_FIX_THK;
            end
            S_FIX_THK:
            begin
                cmd.fix     = 1'b1;
                cmd.div_sel = DIV_THK;
                state_next  = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.block_full ? S_MUL_AVG : S_CHECK;
            end
            S_MUL_AVG:
            begin
                cmd.mul     = 1'b1;
                cmd.div_sel = DIV_AVG;
                state_next  = S_FIX_AVG;
            end
            S_FIX_AVG:
            begin
                cmd.fix     = 1'b1;
                cmd.div_sel = DIV_AVG;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.out_free)
                begin
                    cmd.check  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_tready = (state_reg == S_IDLE);

endmodule

// ----- rtl/core/lts_datapath.sv -----
// conversion, averaging, window check, alarm timers and output register
module lts_datapath
    import lts_pkg::*;
#(
    parameter int AVG_SAMPLES = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  logic [IN_TUSER_W-1:0]  in_tuser,
    output logic                   out_tvalid,
    input  logic                   out_tready,
    output logic [OUT_TDATA_W-1:0] out_tdata,
    output logic [OUT_TUSER_W-1:0] out_tuser,
    input  cmd_t                   cmd,
    output status_t                status
);

    localparam int SUM_W = $clog2(AVG_SAMPLES * THICK_MAX + 1);
    localparam int CNT_W = $clog2(AVG_SAMPLES + 1);
    localparam logic [RECIP_W-1:0] RECIP_AVG =
        RECIP_W'((64'd1 << RECIP_SHIFT) / AVG_SAMPLES);

    // configuration
    logic [EXP_W-1:0] exp_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [TMO_W-1:0] tmo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= EXPECTED_RST;
            tol_reg <= TOLERANCE_RST;
            tmo_reg <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_EXPECTED:  exp_reg <= cfg_data[EXP_W-1:0];
                CFG_TOLERANCE: tol_reg <= cfg_data[TOL_W-1:0];
                CFG_TIMEOUT:   tmo_reg <= cfg_data[TMO_W-1:0];
                default:       ;
            endcase
        end
    end

    // captured item and divider registers (payload, no reset)
    logic [TIME_W-1:0]     now_reg;
    logic                  gates_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [THICK_W-1:0]    q_reg;

    logic [DIVIDEND_W-1:0] code_scaled;
    logic [MV_W-1:0]       head_room;
    logic [DIVIDEND_W-1:0] thk_scaled;

    assign code_scaled = DIVIDEND_W'(in_tdata[CODE_W-1:0]) * DIVIDEND_W'(FULL_SCALE_MV);
    assign head_room   = FULL_SCALE_MV - q_reg[MV_W-1:0];
    assign thk_scaled  = DIVIDEND_W'(head_room) * DIVIDEND_W'(THICK_GAIN);

    // divisor and reciprocal for the active division
    logic [DIVISOR_W-1:0] divisor;
    logic [RECIP_W-1:0]   recip;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_MV:
            begin
                divisor = DIVISOR_W'(ADC_MAX);
                recip   = RECIP_MV;
            end
            DIV_THK:
            begin
                divisor = DIVISOR_W'(THICK_SCALE);
                recip   = RECIP_THK;
            end
            DIV_AVG:
            begin
                divisor = DIVISOR_W'(AVG_SAMPLES);
                recip   = RECIP_AVG;
            end
            default:
            begin
                divisor = DIVISOR_W'(ADC_MAX);
                recip   = RECIP_MV;
            end
        endcase
    end

    // estimate is exact or one low
    logic [DIVIDEND_W-1:0]           q_est;
    logic [DIVIDEND_W+DIVISOR_W-1:0] q_times_d;
    logic [DIVIDEND_W-1:0]           rem;
    logic [DIVIDEND_W-1:0]           q_fix;

    assign q_est     = prod_reg[RECIP_SHIFT +: DIVIDEND_W];
    assign q_times_d = (DIVIDEND_W+DIVISOR_W)'(q_est) * (DIVIDEND_W+DIVISOR_W)'(divisor);
    assign rem       = dividend_reg - q_times_d[DIVIDEND_W-1:0];
    assign q_fix     = (rem >= DIVIDEND_W'(divisor)) ? q_est + 1'b1 : q_est;

    // accumulator
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_inc;
    logic              block_full;

    assign sum_next   = sum_reg + SUM_W'(q_reg);
    assign count_inc  = count_reg + 1'b1;
    assign block_full = (count_inc >= CNT_W'(AVG_SAMPLES));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg      <= in_tdata[CODE_W +: TIME_W];
            gates_reg    <= in_tuser[0] & in_tuser[1];
            dividend_reg <= code_scaled;
        end
        else if (cmd.load_thk)
        begin
            dividend_reg <= thk_scaled;
        end
        else if (cmd.accum && block_full)
        begin
            dividend_reg <= DIVIDEND_W'(sum_next);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(dividend_reg) * PROD_W'(recip);
        end
        if (cmd.fix)
        begin
            q_reg <= q_fix[THICK_W-1:0];
        end
    end

    // window check
    logic [THICK_W-1:0]       held_avg_reg;
    logic                     updated_reg;
    logic signed [EXP_W+1:0]  win_lo;
    logic        [EXP_W:0]    win_hi;
    logic                     below;
    logic                     above;
    logic [TIME_W-1:0]        thin_start_reg;
    logic [TIME_W-1:0]        thick_start_reg;
    logic                     thin_armed_reg;
    logic                     thick_armed_reg;
    logic [TIME_W-1:0]        thin_elapsed;
    logic [TIME_W-1:0]        thick_elapsed;
    logic                     thin_fire;
    logic                     thick_fire;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_tdata_reg;
    logic [OUT_TUSER_W-1:0]   out_tuser_reg;

    assign win_lo = $signed({2'b00, exp_reg}) - $signed({6'b000000, tol_reg});
    assign win_hi = {1'b0, exp_reg} + {5'b00000, tol_reg};
    assign below  = $signed({3'b000, held_avg_reg}) < win_lo;
    assign above  = {2'b00, held_avg_reg} > win_hi;

    assign thin_elapsed  = now_reg - thin_start_reg;
    assign thick_elapsed = now_reg - thick_start_reg;

    // a side armed in this very item has zero elapsed time and cannot fire
    assign thin_fire  = gates_reg & below & thin_armed_reg
                      & (thin_elapsed > TIME_W'(tmo_reg));
    assign thick_fire = gates_reg & above & thick_armed_reg
                      & (thick_elapsed > TIME_W'(tmo_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            count_reg       <= '0;
            held_avg_reg    <= '0;
            updated_reg     <= 1'b0;
            thin_start_reg  <= '0;
            thick_start_reg <= '0;
            thin_armed_reg  <= 1'b0;
            thick_armed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                updated_reg <= 1'b0;
            end
            if (cmd.accum)
            begin
                if (block_full)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_inc;
                end
            end
            if (cmd.fix && (cmd.div_sel == DIV_AVG))
            begin
                held_avg_reg <= q_fix[THICK_W-1:0];
                updated_reg  <= 1'b1;
            end
            if (cmd.check)
            begin
                thin_armed_reg  <= gates_reg & below & ~thin_fire;
                thick_armed_reg <= gates_reg & above & ~thick_fire;
                if (gates_reg && below && !thin_armed_reg)
                begin
                    thin_start_reg <= now_reg;
                end
                if (gates_reg && above && !thick_armed_reg)
                begin
                    thick_start_reg <= now_reg;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            out_tdata_reg <= OUT_TDATA_W'(held_avg_reg);
            out_tuser_reg <= {thick_fire, thin_fire, updated_reg};
        end
    end

    assign status.block_full = block_full;
    assign status.out_free   = ~out_valid_reg | out_tready;

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_tdata_reg;
    assign out_tuser  = out_tuser_reg;

endmodule

// ----- rtl/core/lts_checker.sv -----
// port-level assertions for the thickness supervisor and their bind
module lts_port_checker
    import lts_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // one sample in flight: tready drops right after an input transfer
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample is still in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed or dropped");

    // thin and thick sides are exclusive
    a_alarm_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]))
        else $error("thin and thick alarm in the same result");

    // average stays within the sensor thickness span
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[THICK_W-1:0] <= THICK_W'(THICK_MAX)))
        else $error("average thickness out of range");

endmodule

bind laser_thickness_supervisor lts_port_checker u_lts_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/lts_checker.sv -----
// checker for the laser thickness supervisor: watches the config port and both streams
`timescale 1ns / 100ps

module lts_checker
    import lts_pkg::*;
#(
    parameter int AVG_SAMPLES = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [OUT_TUSER_W-1:0] m_tuser,
    output int                     fail_count,
    output int                     readings_owed,
    output int                     blocks_seen,
    output int                     thin_seen,
    output int                     thick_seen
);

    typedef struct packed {
        logic [THICK_W-1:0] avg_um;
        logic               updated;
        logic               thin;
        logic               thick;
    } reading_t;

    // register copies
    logic [EXP_W-1:0] exp_um;
    logic [TOL_W-1:0] tol_um;
    logic [TMO_W-1:0] tmo_ms;

    // supervisor state copy
    int unsigned        acc_um;
    int unsigned        acc_count;
    logic [THICK_W-1:0] held_um;
    logic [TIME_W-1:0]  thin_t0;
    logic [TIME_W-1:0]  thick_t0;
    bit                 thin_on;
    bit                 thick_on;

    reading_t awaited_readings[$];
    int       errors;
    int       blocks;
    int       thins;
    int       thicks;

    function automatic int unsigned code_to_um(input logic [CODE_W-1:0] code);
        int unsigned c;
        int unsigned mv;
        c  = 32'(code);
        mv = (c * 10000) / ADC_MAX;
        if (mv > 10000)
            mv = 10000;
        return ((10000 - mv) * THICK_GAIN) / THICK_SCALE;
    endfunction

    // averaging first, then the window check on the new held value
    function automatic reading_t supervise(input logic [CODE_W-1:0] code,
                                           input logic [TIME_W-1:0] now,
                                           input bit en, input bit pos);
        reading_t r;
        int avg;
        int e;
        int t;
        int lo;
        int hi;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        acc_um = acc_um + code_to_um(code);
        acc_count++;
        if (acc_count >= AVG_SAMPLES)
        begin
            held_um   = THICK_W'(acc_um / AVG_SAMPLES);
            acc_um    = 0;
            acc_count = 0;
            r.updated = 1'b1;
        end
        if (en && pos)
        begin
            avg = 32'(held_um);
            e   = 32'(exp_um);
            t   = 32'(tol_um);
            lo  = e - t;
            hi  = e + t;
            if (avg >= lo && avg <= hi)
            begin
                thin_on  = 0;
                thick_on = 0;
            end
            else if (avg < lo)
            begin
                thick_on = 0;
                if (!thin_on)
                begin
                    thin_on = 1;
                    thin_t0 = now;
                end
            end
            else
            begin
                thin_on = 0;
                if (!thick_on)
                begin
                    thick_on = 1;
                    thick_t0 = now;
                end
            end
            // thick side goes first
            elapsed = now - thick_t0;
            if (thick_on && elapsed > TIME_W'(tmo_ms))
            begin
                r.thick  = 1'b1;
                thick_on = 0;
            end
            elapsed = now - thin_t0;
            if (thin_on && elapsed > TIME_W'(tmo_ms))
            begin
                r.thin  = 1'b1;
                thin_on = 0;
            end
        end
        else
        begin
            thin_on  = 0;
            thick_on = 0;
        end
        r.avg_um = held_um;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            exp_um    = EXPECTED_RST;
            tol_um    = TOLERANCE_RST;
            tmo_ms    = TIMEOUT_RST;
            acc_um    = 0;
            acc_count = 0;
            held_um   = '0;
            thin_t0   = '0;
            thick_t0  = '0;
            thin_on   = 0;
            thick_on  = 0;
            awaited_readings.delete();
            errors = 0;
            blocks = 0;
            thins  = 0;
            thicks = 0;
        end
        else
        begin
            // result transfer against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.avg_um  = m_tdata[THICK_W-1:0];
                got.updated = m_tuser[0];
                got.thin    = m_tuser[1];
                got.thick   = m_tuser[2];
                if (got.updated) blocks++;
                if (got.thin) thins++;
                if (got.thick) thicks++;
                if (awaited_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none, got avg %0d flags %b",
                             $time, got.avg_um, m_tuser);
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (got.avg_um !== want.avg_um)
                    begin
                        errors++;
                        $display("%0t avg_thickness_um mismatch: expected %0d, got %0d",
                                 $time, want.avg_um, got.avg_um);
                    end
                    if (got.updated !== want.updated)
                    begin
                        errors++;
                        $display("%0t avg_updated mismatch: expected %b, got %b",
                                 $time, want.updated, got.updated);
                    end
                    if (got.thin !== want.thin)
                    begin
                        errors++;
                        $display("%0t thin_alarm mismatch: expected %b, got %b",
                                 $time, want.thin, got.thin);
                    end
                    if (got.thick !== want.thick)
                    begin
                        errors++;
                        $display("%0t thick_alarm mismatch: expected %b, got %b",
                                 $time, want.thick, got.thick);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EXPECTED:  exp_um = cfg_data[EXP_W-1:0];
                    CFG_TOLERANCE: tol_um = cfg_data[TOL_W-1:0];
                    CFG_TIMEOUT:   tmo_ms = cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_readings.push_back(supervise(s_tdata[CODE_W-1:0],
                                                     s_tdata[CODE_W +: TIME_W],
                                                     s_tuser[0], s_tuser[1]));
        end
        fail_count    <= errors;
        readings_owed <= awaited_readings.size();
        blocks_seen   <= blocks;
        thin_seen     <= thins;
        thick_seen    <= thicks;
    end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top for the laser thickness supervisor: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb;
    import lts_pkg::*;

    localparam int AVG_SAMPLES = 10;
    // no register lives at this index, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = CFG_EXPECTED;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // adc_code[11:0], now_ms[43:12], zero pad
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // head_enable[0], at_print_height[1]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // avg_thickness_um[14:0], zero pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // avg_updated[0], thin_alarm[1], thick_alarm[2]

    int fail_count;
    int readings_owed;
    int blocks_seen;
    int thin_seen;
    int thick_seen;

    // stimulus bookkeeping
    bit          quiet;          // when set neither side idles
    int          samples_sent;
    int          settings_used;
    logic [31:0] clock_ms;

    always #5 clk = ~clk;

    laser_thickness_supervisor #(.AVG_SAMPLES(AVG_SAMPLES)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lts_checker #(.AVG_SAMPLES(AVG_SAMPLES)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .s_tuser       (s_axis_tuser),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tuser       (m_axis_tuser),
        .fail_count    (fail_count),
        .readings_owed (readings_owed),
        .blocks_seen   (blocks_seen),
        .thin_seen     (thin_seen),
        .thick_seen    (thick_seen)
    );

    function automatic int idle_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // one sample transfer; valid stays up across back-to-back samples
    task automatic send_sample(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now,
                               input bit en, input bit pos);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, now, code};
        s_axis_tuser  <= {pos, en};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // stop sending and wait for every predicted result to come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_owed != 0)
            @(posedge clk);
    endtask

    // caller lowers cfg_we after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_window(input logic [15:0] exp_val, input logic [15:0] tol_val,
                              input logic [15:0] tmo_val);
        write_reg(CFG_EXPECTED, exp_val);
        write_reg(CFG_TOLERANCE, tol_val);
        write_reg(CFG_TIMEOUT, tmo_val);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // result side: random stall before each result transfer
    initial
    begin : result_sink
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = idle_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int          r;
        int          c;
        int          base;
        int          span;
        int          aim;
        bit          en;
        bit          pos;
        logic [15:0] exp_val;
        logic [15:0] tol_val;
        logic [15:0] tmo_val;
        quiet         = 0;
        samples_sent  = 0;
        settings_used = 1;
        clock_ms      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset window, full-thick samples close a block and arm the thick side
        for (int i = 0; i < AVG_SAMPLES; i++)
            send_sample(12'd0, 32'(i * 10), 1'b1, 1'b1);
        // just past the default timeout
        send_sample(12'd4095, 32'd2091, 1'b1, 1'b1);
        // both gates clear
        send_sample(12'd4095, 32'd2100, 1'b0, 1'b0);
        drain();

        // window far above any average, zero timeout, arming at time zero
        set_window(16'hFFFF, 16'h0000, 16'h0000);
        send_sample(12'd2048, 32'd0, 1'b1, 1'b1);
        send_sample(12'd1, 32'd1, 1'b1, 1'b1);
        // one gate clear at a time
        send_sample(12'd4094, 32'd2, 1'b1, 1'b0);
        send_sample(12'd2047, 32'd3, 1'b0, 1'b1);
        drain();

        // oversized tolerance gets masked, lower bound goes negative, timestamp wraps
        set_window(16'h0000, 16'hFFFF, 16'hFFFF);
        send_sample(12'd100, 32'hFFFF_FF00, 1'b1, 1'b1);
        send_sample(12'd4000, 32'h0000_FFFF, 1'b1, 1'b1);
        send_sample(12'd1, 32'h8000_0000, 1'b1, 1'b1);
        send_sample(12'd4094, 32'h8000_0001, 1'b1, 1'b1);
        drain();

        // random phases, each under its own register setting
        for (int phase = 0; phase < 9; phase++)
        begin
            quiet = (phase % 4 == 1);
            base  = $urandom_range(0, 4095);
            span  = $urandom_range(0, 400);
            r     = $urandom_range(0, 3);
            if (r == 0)
            begin
                exp_val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                tol_val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                tmo_val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            else if (r == 1)
            begin
                exp_val = 16'($urandom_range(0, THICK_MAX));
                tol_val = 16'($urandom_range(0, 3000)) | 16'($urandom_range(0, 15) << 12);
                tmo_val = 16'($urandom_range(0, 300));
            end
            else
            begin
                // aim the window roughly at the thickness this phase produces
                aim = THICK_MAX - (base * 5421) / 1000 + $urandom_range(0, 1000) - 500;
                if (aim < 0)
                    aim = 0;
                exp_val = 16'(aim);
                tol_val = 16'($urandom_range(50, 1500));
                tmo_val = $urandom_range(0, 1) ? 16'($urandom_range(0, 300))
                                               : 16'($urandom_range(0, 65535));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, 16'($urandom));
            set_window(exp_val, tol_val, tmo_val);
            clock_ms = (phase % 2 == 1) ? 32'($urandom)
                                        : 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));

            for (int i = 0; i < 48; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    c = $urandom_range(0, 4095);
                else
                begin
                    c = base + $urandom_range(0, 2 * span) - span;
                    if (c < 0)
                        c = 0;
                    if (c > 4095)
                        c = 4095;
                end
                // mostly both gates set, now and then one or both dropped
                r   = $urandom_range(0, 19);
                en  = (r != 0) && (r != 1);
                pos = (r != 0) && (r != 2);
                if ($urandom_range(0, 9) == 0)
                    clock_ms = clock_ms + 32'($urandom);
                else
                    clock_ms = clock_ms + 32'($urandom_range(0, tmo_val / 8 + 3));
                send_sample(CODE_W'(c), clock_ms, en, pos);
            end
            drain();
        end

        quiet = 1;
        repeat (20) @(posedge clk);
        $display("covered %0d samples under %0d register settings with random stalls",
                 samples_sent, settings_used);
        $display("saw %0d averaging blocks, %0d thin alarms and %0d thick alarms",
                 blocks_seen, thin_seen, thick_seen);
        if (fail_count == 0 && readings_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin : watchdog
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- laser_thickness_supervisor.f -----
rtl/core/lts_pkg.sv
rtl/core/lts_ctrl.sv
rtl/core/lts_datapath.sv
rtl/core/laser_thickness_supervisor.sv
rtl/core/lts_checker.sv
tb/sv/lts_checker.sv
tb/sv/tb.sv
